// ===== hw/rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Types and constants shared by the escape-time core and its stream interface.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int COUNT_W  = 17;
    localparam int COLOR_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int FRAC_BITS      = 28;
    localparam int MAX_ITERATIONS = 65536;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_CENTER_RE  = 3'd0;
    localparam t_cfg_index CFG_CENTER_IM  = 3'd1;
    localparam t_cfg_index CFG_PIXEL_STEP = 3'd2;
    localparam t_cfg_index CFG_WIDTH      = 3'd3;
    localparam t_cfg_index CFG_HEIGHT     = 3'd4;
    localparam t_cfg_index CFG_ITER_LIMIT = 3'd5;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_pix_word;

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic [COLOR_W-1:0] color_index;
    } t_res_word;

endpackage

// ===== hw/rtl/met_stream_if.sv =====
// ----------------------------------------------------------------------------
// met_stream_if
// Valid/ready stream carrying one word per handshake.
// ----------------------------------------------------------------------------
interface met_stream_if #(
    parameter type T_WORD = logic
) ();

    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Mandelbrot escape-time evaluator: maps a pixel to a point c in signed
// Q4.28 and counts z = z^2 + c iterations until escape or the limit.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time. After acceptance the states S_MAPR,
// S_MAPI and S_CI map the pixel to c. Each iteration runs S_RR, S_II, S_RI
// and S_UPD because a single 32x32 signed multiplier forms zr*zr, zi*zi and
// zr*zi in turn before the update step, and an escaping point runs one last
// iteration that only tests. The S_DONE state moves the result into the
// output register, and it is held for as long as the previous result word
// is still waiting for the sink. The result word then waits there while the
// next pixel is already being worked on. Configuration is to be written
// through the plain write port only while the core is idle; the core
// itself does not enforce this.
module mandelbrot_escape_time_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  met_pkg::t_cfg_index   i_cfg_index,
    input  logic [met_pkg::CFG_W-1:0] i_cfg_data,
    met_stream_if.sink            i_pix,
    met_stream_if.source          o_res
);
    import met_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAPR = 4'd1;
    localparam logic [3:0] S_MAPI = 4'd2;
    localparam logic [3:0] S_CI   = 4'd3;
    localparam logic [3:0] S_RR   = 4'd4;
    localparam logic [3:0] S_II   = 4'd5;
    localparam logic [3:0] S_RI   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam int ESC_SHIFT = (2 * FRAC_BITS + 2 > 64) ? 64 : 2 * FRAC_BITS + 2;
    localparam logic [64:0] ESC_LIMIT = 65'd1 << ESC_SHIFT;
    localparam logic [COUNT_W-1:0] MAX_ITER = COUNT_W'(MAX_ITERATIONS);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // configuration
    logic signed [31:0]        r_center_re;
    logic signed [31:0]        r_center_im;
    logic [30:0]               r_step;
    logic [12:0]               r_width;
    logic [12:0]               r_height;
    logic [COUNT_W-1:0]        r_iter_limit;

    // sequencer and datapath
    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [13:0]        r_dc;
    logic signed [13:0]        r_dr;
    logic signed [63:0]        r_prod;
    logic [63:0]               r_rr;
    logic signed [63:0]        r_diff;
    logic                      r_esc_ok;
    logic signed [31:0]        r_cr;
    logic signed [31:0]        r_ci;
    logic signed [31:0]        r_zr;
    logic signed [31:0]        r_zi;
    logic [COUNT_W-1:0]        r_count;

    // output register
    logic                      r_out_valid;
    logic [COUNT_W-1:0]        r_out_count;
    logic [COLOR_W-1:0]        r_out_color;

    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [63:0]        prod_full;
    logic [COUNT_W-1:0]        lim_eff;
    logic [COUNT_W-1:0]        count_inc;
    logic [64:0]               mag_sum;
    logic                      pix_acc;

    assign lim_eff   = (r_iter_limit > MAX_ITER) ? MAX_ITER : r_iter_limit;
    assign count_inc = r_count + COUNT_W'(1);
    assign pix_acc   = i_pix.valid && i_pix.ready;
    assign mag_sum   = {1'b0, r_rr} + {1'b0, $unsigned(r_prod)};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MAPR: begin
                mul_a = $signed({1'b0, r_step});
                mul_b = 32'(r_dc);
            end
            S_MAPI: begin
                mul_a = $signed({1'b0, r_step});
                mul_b = 32'(r_dr);
            end
            S_RR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            S_II: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            S_RI: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) n_state = S_MAPR;
            end
            S_MAPR: n_state = S_MAPI;
            S_MAPI: n_state = S_CI;
            S_CI: begin
                n_state = (COUNT_W'(1) < lim_eff) ? S_RR : S_DONE;
            end
            S_RR:   n_state = S_II;
            S_II:   n_state = S_RI;
            S_RI:   n_state = S_UPD;
            S_UPD: begin
                if (!r_esc_ok || !(count_inc < lim_eff)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RR;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re  <= '0;
            r_center_im  <= '0;
            r_step       <= 31'd2097152;
            r_width      <= 13'd256;
            r_height     <= 13'd256;
            r_iter_limit <= COUNT_W'(256);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CENTER_RE:  r_center_re  <= $signed(i_cfg_data);
                CFG_CENTER_IM:  r_center_im  <= $signed(i_cfg_data);
                CFG_PIXEL_STEP: r_step       <= i_cfg_data[30:0];
                CFG_WIDTH:      r_width      <= i_cfg_data[12:0];
                CFG_HEIGHT:     r_height     <= i_cfg_data[12:0];
                CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    r_dc <= $signed({2'b00, i_pix.data.column}) - $signed({2'b00, r_width[12:1]});
                    r_dr <= $signed({2'b00, r_height[12:1]}) - $signed({2'b00, i_pix.data.row});
                end
            end
            S_MAPR: r_prod <= prod_full;
            S_MAPI: begin
                r_prod <= prod_full;
                r_cr   <= sat32(64'(r_center_re) + r_prod);
            end
            S_CI: begin
                r_ci    <= sat32(64'(r_center_im) + r_prod);
                r_zi    <= sat32(64'(r_center_im) + r_prod);
                r_zr    <= r_cr;
                r_count <= COUNT_W'(1);
            end
            S_RR: r_prod <= prod_full;
            S_II: begin
                r_rr   <= $unsigned(r_prod);
                r_prod <= prod_full;
            end
            S_RI: begin
                // exact escape test on the full-width sum of squares
                r_esc_ok <= mag_sum < ESC_LIMIT;
                r_diff   <= $signed(r_rr) - r_prod;
                r_prod   <= prod_full;
            end
            S_UPD: begin
                if (r_esc_ok) begin
                    r_zr    <= sat32((r_diff >>> FRAC_BITS) + 64'(r_cr));
                    r_zi    <= sat32((r_prod >>> (FRAC_BITS - 1)) + 64'(r_ci));
                    r_count <= count_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) r_out_valid <= 1'b0;
            if (r_state == S_DONE && (!r_out_valid || o_res.ready)) r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
            r_out_count <= r_count;
            r_out_color <= COLOR_W'(r_count & (lim_eff - COUNT_W'(1)));
        end
    end

    assign i_pix.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_out_valid;
    assign o_res.data.escape_count = r_out_count;
    assign o_res.data.color_index  = r_out_color;

    a_iter_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RR) |-> (r_count < lim_eff))
        else $error("iteration started at or above the limit");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.escape_count != '0) &&
        ((o_res.data.escape_count <= lim_eff) || (o_res.data.escape_count == COUNT_W'(1))))
        else $error("escape count out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word loaded outside the done step");

endmodule
